@@ sv/qrrp_pkg.sv @@
`timescale 1ns / 1ps

package qrrp_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned LEN_W = 16;

  localparam logic [POS_W-1:0] HEADER_BYTES    = 17'd7;
  localparam logic [POS_W-1:0] POS_MAX         = 17'h1FFFF;
  localparam logic [POS_W:0]   ENTRY_HDR_BYTES = 18'd3;
  localparam logic [7:0]       RESULT_TYPE     = 8'h02;
  localparam logic [LEN_W-1:0] RESULT_MIN_LEN  = 16'd4;

  localparam logic [POS_W-1:0] POS_ID_LO  = 17'd3;
  localparam logic [POS_W-1:0] POS_ID_HI  = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO = 17'd5;
  localparam logic [POS_W-1:0] POS_LEN_HI = 17'd6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_PROTO  = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] message_id;
    logic [15:0] result_code;
    logic [15:0] error_code;
  } result_t;

  typedef struct packed {
    logic item_vld;
    logic out_free;
  } core_ctl_t;

endpackage

@@ sv/qrrp_in_if.sv @@
`timescale 1ns / 1ps

interface qrrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/qrrp_out_if.sv @@
`timescale 1ns / 1ps

interface qrrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] message_id;
  logic [15:0] result_code;
  logic [15:0] error_code;

  modport source(output valid, output status, output message_id, output result_code,
                 output error_code, input ready);
  modport sink(input valid, input status, input message_id, input result_code,
               input error_code, output ready);
endinterface

@@ sv/qrrp_in_stage.sv @@
`timescale 1ns / 1ps

module qrrp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  qrrp_in_if.sink            in_ch,
  input  logic               consume,
  output logic               item_vld,
  output qrrp_pkg::in_item_t item
);
  import qrrp_pkg::*;

  logic     vld_r;
  in_item_t item_r;
  logic     load;

  assign in_ch.ready = !vld_r || consume;
  assign load        = in_ch.valid && in_ch.ready;
  assign item_vld    = vld_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (consume) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

endmodule

@@ sv/qrrp_parse.sv @@
`timescale 1ns / 1ps

module qrrp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  qrrp_pkg::core_ctl_t ctl,
  input  qrrp_pkg::in_item_t  item,
  output logic                consume,
  output logic                res_vld,
  output qrrp_pkg::result_t   res
);
  import qrrp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [LEN_W-1:0] area_r, area_nxt;
  logic [POS_W-1:0] noff_r, noff_nxt;
  logic [7:0]       etype_r, etype_nxt;
  logic [LEN_W-1:0] elen_r, elen_nxt;
  logic             stop_r, stop_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      cres_r, cres_nxt;
  logic [15:0]      cerr_r, cerr_nxt;

  logic [7:0]       b;
  logic [POS_W:0]   p_x;
  logic [POS_W:0]   off_x;
  logic [POS_W:0]   area_end;
  logic [POS_W:0]   entry_end;
  logic [LEN_W-1:0] len_full;
  logic [POS_W:0]   msg_len;
  logic             proto;

  assign consume = ctl.item_vld && (!item.last_byte || ctl.out_free);
  assign res_vld = consume && item.last_byte;

  always_comb begin
    pos_nxt   = pos_r;
    id_nxt    = id_r;
    area_nxt  = area_r;
    noff_nxt  = noff_r;
    etype_nxt = etype_r;
    elen_nxt  = elen_r;
    stop_nxt  = stop_r;
    found_nxt = found_r;
    cres_nxt  = cres_r;
    cerr_nxt  = cerr_r;

    b         = item.data_byte;
    p_x       = {1'b0, pos_r};
    off_x     = {1'b0, noff_r};
    len_full  = {b, elen_r[7:0]};

    if (pos_r == POS_ID_LO) begin
      id_nxt = {8'h00, b};
    end else if (pos_r == POS_ID_HI) begin
      id_nxt = {b, id_r[7:0]};
    end else if (pos_r == POS_LEN_LO) begin
      area_nxt = {8'h00, b};
    end else if (pos_r == POS_LEN_HI) begin
      area_nxt = {b, area_r[7:0]};
    end

    area_end  = {1'b0, HEADER_BYTES} + {2'b00, area_nxt};
    entry_end = off_x + ENTRY_HDR_BYTES + {2'b00, len_full};

    if (pos_r >= HEADER_BYTES && !stop_r && !found_r && p_x < area_end) begin
      if (p_x == off_x) begin
        if (off_x + ENTRY_HDR_BYTES > area_end) begin
          stop_nxt = 1'b1;
        end else begin
          etype_nxt = b;
        end
      end else if (p_x == off_x + 18'd1) begin
        elen_nxt = {8'h00, b};
      end else if (p_x == off_x + 18'd2) begin
        elen_nxt = len_full;
        if (entry_end > area_end) begin
          stop_nxt = 1'b1;
        end else if (!(etype_r == RESULT_TYPE && len_full >= RESULT_MIN_LEN)) begin
          noff_nxt = entry_end[POS_W-1:0];
        end
      end else if (p_x == off_x + 18'd3) begin
        cres_nxt = {8'h00, b};
      end else if (p_x == off_x + 18'd4) begin
        cres_nxt = {b, cres_r[7:0]};
      end else if (p_x == off_x + 18'd5) begin
        cerr_nxt = {8'h00, b};
      end else if (p_x == off_x + 18'd6) begin
        cerr_nxt  = {b, cerr_r[7:0]};
        found_nxt = 1'b1;
      end
    end

    msg_len = p_x + 18'd1;
    proto   = (msg_len < {1'b0, HEADER_BYTES}) || (area_end > msg_len);

    res = '0;
    if (proto) begin
      res.status = STATUS_PROTO;
    end else if (found_nxt) begin
      res.status      = STATUS_OK;
      res.message_id  = id_nxt;
      res.result_code = cres_nxt;
      res.error_code  = cerr_nxt;
    end else begin
      res.status     = STATUS_ABSENT;
      res.message_id = id_nxt;
    end

    if (item.last_byte) begin
      pos_nxt   = '0;
      id_nxt    = '0;
      area_nxt  = '0;
      noff_nxt  = HEADER_BYTES;
      etype_nxt = '0;
      elen_nxt  = '0;
      stop_nxt  = 1'b0;
      found_nxt = 1'b0;
      cres_nxt  = '0;
      cerr_nxt  = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      id_r    <= '0;
      area_r  <= '0;
      noff_r  <= HEADER_BYTES;
      etype_r <= '0;
      elen_r  <= '0;
      stop_r  <= 1'b0;
      found_r <= 1'b0;
      cres_r  <= '0;
      cerr_r  <= '0;
    end else if (consume) begin
      pos_r   <= pos_nxt;
      id_r    <= id_nxt;
      area_r  <= area_nxt;
      noff_r  <= noff_nxt;
      etype_r <= etype_nxt;
      elen_r  <= elen_nxt;
      stop_r  <= stop_nxt;
      found_r <= found_nxt;
      cres_r  <= cres_nxt;
      cerr_r  <= cerr_nxt;
    end
  end

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (pos_r == '0) && (noff_r == HEADER_BYTES) && !found_r && !stop_r)
    else $error("parser state not cleared after last item");

  a_stop_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stop_r && found_r))
    else $error("walk stopped and result found together");

  a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
    noff_r >= HEADER_BYTES)
    else $error("entry offset below header");

  a_proto_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.status == STATUS_PROTO) |-> (res.message_id == '0))
    else $error("message id reported on protocol error");

endmodule

@@ sv/qrrp_out_stage.sv @@
`timescale 1ns / 1ps

module qrrp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  qrrp_pkg::result_t res,
  output logic              out_free,
  qrrp_out_if.source        out_ch
);
  import qrrp_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign out_free           = !vld_r || out_ch.ready;
  assign out_ch.valid       = vld_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.message_id  = res_r.message_id;
  assign out_ch.result_code = res_r.result_code;
  assign out_ch.error_code  = res_r.error_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_vld) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

endmodule

@@ sv/qmi_response_result_parser.sv @@
`timescale 1ns / 1ps
// Path: the last byte of a message is held in the input register, then its status item is
// written to the result register, from which it leaves on out_ch.
// Throughput: one byte per cycle, set by the single pass from input register to result
// register; a last byte waits only while the result register is full and not being taken.
// Reset: synchronous, active low; clears the position, walk state and both valid flags.

module qmi_response_result_parser (
  input  logic       clk,
  input  logic       rst_n,
  qrrp_in_if.sink    in_ch,
  qrrp_out_if.source out_ch
);
  import qrrp_pkg::*;

  logic      item_vld;
  in_item_t  item;
  logic      consume;
  logic      res_vld;
  result_t   res;
  logic      out_free;
  core_ctl_t ctl;

  assign ctl.item_vld = item_vld;
  assign ctl.out_free = out_free;

  qrrp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .consume  (consume),
    .item_vld (item_vld),
    .item     (item)
  );

  qrrp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .item    (item),
    .consume (consume),
    .res_vld (res_vld),
    .res     (res)
  );

  qrrp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
